// ===== rtl/core/ncet_pkg.sv =====
// ----------------------------------------------------------------------------
// ncet_pkg
// Shared types and constants of the call-event exclusive-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package ncet_pkg;

   localparam int ID_W        = 4;
   localparam int TIME_W      = 32;
   localparam int TOTAL_W     = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;
   localparam int ID_SPACE    = 16;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [1:0] STATUS_BACKWARD  = 2'd3;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_END   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_COMMIT
   } ncet_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic read;
      logic calc;
      logic commit;
   } ncet_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } ncet_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/ncet_ctrl.sv =====
// ----------------------------------------------------------------------------
// ncet_ctrl
// Sequencer: accept a request, read the stack top, evaluate, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module ncet_ctrl
   import ncet_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire ncet_sts_type sts,
   output ncet_cmd_type      cmd
);

   ncet_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the output register is free
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/ncet_datapath.sv =====
// ----------------------------------------------------------------------------
// ncet_datapath
// Call stack memory, time register, totals table and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncet_datapath
   import ncet_pkg::*;
#(
   parameter int MAX_FUNCS   = 16,
   parameter int STACK_DEPTH = 16
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ncet_cmd_type            cmd,
   output ncet_sts_type                 sts,
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                    req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   output logic [RSP_TUSER_W-1:0]       rsp_tuser
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TD = (MAX_FUNCS < ID_SPACE) ? MAX_FUNCS : ID_SPACE;
   localparam int TW = (TD > 1) ? $clog2(TD) : 1;

   // request registers
   logic              cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] ts_ff;

   // architectural state
   logic [ID_W-1:0]    stack_mem [STACK_DEPTH];
   logic [CW-1:0]      count_ff;
   logic [TIME_W:0]    nut_ff;
   logic [TOTAL_W-1:0] tot_ff [TD];

   // evaluation registers
   logic [ID_W-1:0] top_ff;
   logic [1:0]      status_ff;
   logic            credit_ff;
   logic [TIME_W:0] delta_ff;
   logic [TIME_W:0] new_time_ff;

   // result register
   logic                rsp_valid_ff;
   logic                out_credited_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [TOTAL_W-1:0]  out_total_ff;
   logic [1:0]          out_status_ff;

   logic [CW-1:0]      count_dec;
   logic [TIME_W:0]    end_time;
   logic [TIME_W+1:0]  diff;
   logic               behind;
   logic [1:0]         status_calc;
   logic               has_entry;
   logic [TOTAL_W-1:0] tot_rd;
   logic [TIME_W+1:0]  sum;
   logic [TOTAL_W-1:0] sat_sum;
   logic               ok;

   assign count_dec = count_ff - CW'(1);
   assign end_time  = {1'b0, ts_ff} + {{TIME_W{1'b0}}, cmd_ff};
   assign diff      = {1'b0, end_time} - {1'b0, nut_ff};
   assign behind    = diff[TIME_W+1];
   assign has_entry = (32'(top_ff) < 32'(MAX_FUNCS));

   always_comb begin
      status_calc = STATUS_OK;
      if (cmd_ff == CMD_START) begin
         if (32'(count_ff) >= 32'(STACK_DEPTH)) begin
            status_calc = STATUS_OVERFLOW;
         end else if (behind) begin
            status_calc = STATUS_BACKWARD;
         end
      end else begin
         if (count_ff == '0) begin
            status_calc = STATUS_UNDERFLOW;
         end else if (behind) begin
            status_calc = STATUS_BACKWARD;
         end
      end
   end

   assign tot_rd  = tot_ff[top_ff[TW-1:0]];
   assign sum     = {2'b00, tot_rd} + {1'b0, delta_ff};
   assign sat_sum = (sum[TIME_W+1:TOTAL_W] != '0) ? '1 : sum[TOTAL_W-1:0];
   assign ok      = (status_ff == STATUS_OK);

   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_tuser;
         id_ff  <= req_tdata[ID_W-1:0];
         ts_ff  <= req_tdata[ID_W+TIME_W-1:ID_W];
      end
   end

   // stack memory: registered top read, push on commit
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         top_ff <= stack_mem[count_dec[SW-1:0]];
      end
      if (cmd.commit && ok && (cmd_ff == CMD_START)) begin
         stack_mem[count_ff[SW-1:0]] <= id_ff;
      end
   end

   // evaluation
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         status_ff   <= status_calc;
         delta_ff    <= diff[TIME_W:0];
         new_time_ff <= end_time;
         credit_ff   <= (status_calc == STATUS_OK) && (count_ff != '0) && has_entry;
      end
   end

   // stack count, time register and totals
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         nut_ff   <= '0;
         for (int i = 0; i < TD; i++) begin
            tot_ff[i] <= '0;
         end
      end else if (cmd.commit && ok) begin
         nut_ff <= new_time_ff;
         if (cmd_ff == CMD_START) begin
            count_ff <= count_ff + CW'(1);
         end else begin
            count_ff <= count_dec;
         end
         if (credit_ff) begin
            tot_ff[top_ff[TW-1:0]] <= sat_sum;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_credited_ff <= credit_ff;
         out_id_ff       <= credit_ff ? top_ff : '0;
         out_total_ff    <= credit_ff ? sat_sum : '0;
         out_status_ff   <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-ID_W-TOTAL_W){1'b0}}, out_total_ff, out_id_ff};
   assign rsp_tuser  = {out_status_ff, out_credited_ff};

endmodule

`default_nettype wire

// ===== rtl/core/nested_call_exclusive_time.sv =====
// ----------------------------------------------------------------------------
// nested_call_exclusive_time
// Exclusive-time accounting over a stream of nested call events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one call event per request: tuser[0] is the kind
//          (0 start, 1 end), tdata[3:0] the function id, tdata[35:4] the
//          inclusive timestamp.
//   rsp_*  returns one result per request: tuser[0] credited, tuser[2:1]
//          status (ok, overflow, underflow, time backward), tdata[3:0]
//          the credited id and tdata[35:4] its new saturated total.
// Timing: a request's result passes the stack-top memory read, the
//   subtract/compare, then the add and commit, which waits until the result
//   register is free; the next request can be taken in the cycle after the
//   commit, so one request is in flight at a time. The registered read of the
//   call-stack memory and the split of subtract from add set these steps.
// Reset: the stack is emptied, the unaccounted time and all totals go to
//   zero, and the result register is emptied. The stack memory itself is
//   not cleared; only entries below the count are ever used.
// Stall: the result register holds while rsp_tready is low; a new request
//   is still accepted and evaluated, and its commit waits until the result
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module nested_call_exclusive_time
   import ncet_pkg::*;
#(
   parameter int MAX_FUNCS   = 16,
   parameter int STACK_DEPTH = 16
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // tdata: func_id [3:0], timestamp [35:4], zero fill [39:36]
   input  wire logic [REQ_TDATA_W-1:0]  req_tdata,
   // tuser: command [0]
   input  wire logic                    req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // tdata: credited_id [3:0], credited_total [35:4], zero fill [39:36]
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   // tuser: credited [0], status [2:1]
   output logic [RSP_TUSER_W-1:0]       rsp_tuser
);

   ncet_cmd_type cmd;
   ncet_sts_type sts;

   // sequence each request through read, evaluate and commit
   ncet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // stack, time register, totals and result register
   ncet_datapath #(
      .MAX_FUNCS   (MAX_FUNCS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ncet_checker.sv =====
// ----------------------------------------------------------------------------
// ncet_checker
// Port-level checks of the exclusive-time block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ncet_checker
   import ncet_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_TDATA_W-1:0] req_tdata,
   input wire logic                   req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // one request in flight: no acceptance right after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // an error status never credits anything
   a_error_no_credit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[2:1] != STATUS_OK)) |-> !rsp_tuser[0])
      else $error("credit reported with an error status");

   // uncredited results carry zero id and total
   a_uncredited_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("uncredited result carries data");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind nested_call_exclusive_time ncet_checker u_ncet_checker (.*);

`default_nettype wire
